### rtl/mmp3_pkg.sv
// Shared types and constants for the 3x3 modular matrix power block.
// No dependencies; used by mmp3_modmul and modular_matrix_power_3x3.
`default_nettype none

package mmp3_pkg;

    localparam int RESIDUE_BITS  = 30;
    localparam int EXPONENT_BITS = 60;

    localparam logic [31:0] MODULUS_RESET = 32'd1000000007;

    // Word offsets of the three matrices in the scratch memory.
    localparam logic [4:0] OFS_BASE = 5'd0;
    localparam logic [4:0] OFS_ACC  = 5'd9;
    localparam logic [4:0] OFS_PROD = 5'd18;

    localparam logic [3:0] LAST_ENTRY = 4'd8;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD_GO,
        S_LOAD_WAIT,
        S_INIT_ACC,
        S_BIT,
        S_RD_A,
        S_RD_B,
        S_RD_C,
        S_MUL_GO,
        S_MUL_WAIT,
        S_CPY_RD,
        S_CPY_WR,
        S_OUT_RD,
        S_OUT_CAP,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

### rtl/modular_matrix_power_3x3.sv
// Loads and reduces the nine entries, then per exponent bit does one or two
// matrix multiplies, then unloads the nine result entries.
// Takes one matrix at a time; the bit-serial multiply-add unit sets the pace.
// Reset: synchronous, active low; modulus returns to 1000000007, block idles.
// Top level of the 3x3 modular matrix power block.
// Depends on mmp3_pkg and mmp3_modmul.
`default_nettype none

module modular_matrix_power_3x3 #(
    parameter int RESIDUE_BITS  = mmp3_pkg::RESIDUE_BITS,
    parameter int EXPONENT_BITS = mmp3_pkg::EXPONENT_BITS
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [RESIDUE_BITS-1:0]  i_cfg_wdata,
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic [RESIDUE_BITS-1:0]  i_m00,
    input  wire logic [RESIDUE_BITS-1:0]  i_m01,
    input  wire logic [RESIDUE_BITS-1:0]  i_m02,
    input  wire logic [RESIDUE_BITS-1:0]  i_m10,
    input  wire logic [RESIDUE_BITS-1:0]  i_m11,
    input  wire logic [RESIDUE_BITS-1:0]  i_m12,
    input  wire logic [RESIDUE_BITS-1:0]  i_m20,
    input  wire logic [RESIDUE_BITS-1:0]  i_m21,
    input  wire logic [RESIDUE_BITS-1:0]  i_m22,
    input  wire logic [EXPONENT_BITS-1:0] i_power,
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic [RESIDUE_BITS-1:0]       o_r00,
    output logic [RESIDUE_BITS-1:0]       o_r01,
    output logic [RESIDUE_BITS-1:0]       o_r02,
    output logic [RESIDUE_BITS-1:0]       o_r10,
    output logic [RESIDUE_BITS-1:0]       o_r11,
    output logic [RESIDUE_BITS-1:0]       o_r12,
    output logic [RESIDUE_BITS-1:0]       o_r20,
    output logic [RESIDUE_BITS-1:0]       o_r21,
    output logic [RESIDUE_BITS-1:0]       o_r22
);

    localparam logic [RESIDUE_BITS-1:0] MOD_RST =
        mmp3_pkg::MODULUS_RESET[RESIDUE_BITS-1:0];
    localparam logic [RESIDUE_BITS-1:0] RES_ONE = RESIDUE_BITS'(1);

    function automatic logic [4:0] entry_addr(input logic [4:0] ofs,
                                              input logic [1:0] row,
                                              input logic [1:0] col);
        logic [4:0] r3;
        r3 = {2'b00, row, 1'b0} + {3'b000, row};
        return ofs + r3 + {3'b000, col};
    endfunction

    mmp3_pkg::t_state r_state, n_state;

    logic [RESIDUE_BITS-1:0]  r_mod;
    logic [RESIDUE_BITS-1:0]  r_in [9];
    logic [RESIDUE_BITS-1:0]  n_in [9];
    logic [RESIDUE_BITS-1:0]  r_res [9];
    logic [RESIDUE_BITS-1:0]  n_res [9];
    logic [EXPONENT_BITS-1:0] r_exp, n_exp;
    logic [3:0]               r_cnt, n_cnt;
    logic [1:0]               r_i, n_i, r_k, n_k, r_j, n_j;
    logic                     r_sq, n_sq;
    logic [RESIDUE_BITS-1:0]  r_opa, n_opa, r_opb, n_opb;

    logic [RESIDUE_BITS-1:0] mem [27];
    logic [RESIDUE_BITS-1:0] r_rdata;
    logic                    mem_we;
    logic [4:0]              mem_waddr, mem_raddr;
    logic [RESIDUE_BITS-1:0] mem_wdata;

    logic                    mul_start, mul_done;
    logic [RESIDUE_BITS-1:0] mul_a, mul_b, mul_c, mul_res;
    logic [RESIDUE_BITS-1:0] eff_mod, mod_one;
    logic                    in_acc, prod_last, cpy_last;
    logic [4:0]              x_ofs, cpy_dst;

    // A zero modulus behaves as modulus one.
    assign eff_mod = (r_mod == '0) ? RES_ONE : r_mod;
    assign mod_one = (eff_mod == RES_ONE) ? '0 : RES_ONE;

    assign in_acc    = i_in_valid && !o_in_stall;
    assign prod_last = (r_i == 2'd2) && (r_k == 2'd2) && (r_j == 2'd2);
    assign cpy_last  = (r_cnt == mmp3_pkg::LAST_ENTRY);
    assign x_ofs     = r_sq ? mmp3_pkg::OFS_BASE : mmp3_pkg::OFS_ACC;
    assign cpy_dst   = r_sq ? mmp3_pkg::OFS_BASE : mmp3_pkg::OFS_ACC;

    mmp3_modmul #(
        .RESIDUE_BITS(RESIDUE_BITS)
    ) u_modmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .i_c     (mul_c),
        .i_mod   (eff_mod),
        .o_done  (mul_done),
        .o_res   (mul_res)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            mmp3_pkg::S_IDLE:      if (i_in_valid) n_state = mmp3_pkg::S_LOAD_GO;
            mmp3_pkg::S_LOAD_GO:   n_state = mmp3_pkg::S_LOAD_WAIT;
            mmp3_pkg::S_LOAD_WAIT: begin
                if (mul_done) begin
                    n_state = cpy_last ? mmp3_pkg::S_INIT_ACC : mmp3_pkg::S_LOAD_GO;
                end
            end
            mmp3_pkg::S_INIT_ACC:  if (cpy_last) n_state = mmp3_pkg::S_BIT;
            mmp3_pkg::S_BIT: begin
                n_state = (r_exp == '0) ? mmp3_pkg::S_OUT_RD : mmp3_pkg::S_RD_A;
            end
            mmp3_pkg::S_RD_A:      n_state = mmp3_pkg::S_RD_B;
            mmp3_pkg::S_RD_B:      n_state = mmp3_pkg::S_RD_C;
            mmp3_pkg::S_RD_C:      n_state = mmp3_pkg::S_MUL_GO;
            mmp3_pkg::S_MUL_GO:    n_state = mmp3_pkg::S_MUL_WAIT;
            mmp3_pkg::S_MUL_WAIT: begin
                if (mul_done) begin
                    n_state = prod_last ? mmp3_pkg::S_CPY_RD : mmp3_pkg::S_RD_A;
                end
            end
            mmp3_pkg::S_CPY_RD:    n_state = mmp3_pkg::S_CPY_WR;
            mmp3_pkg::S_CPY_WR: begin
                if (!cpy_last) begin
                    n_state = mmp3_pkg::S_CPY_RD;
                end else if (!r_sq) begin
                    n_state = mmp3_pkg::S_RD_A;
                end else begin
                    n_state = mmp3_pkg::S_BIT;
                end
            end
            mmp3_pkg::S_OUT_RD:    n_state = mmp3_pkg::S_OUT_CAP;
            mmp3_pkg::S_OUT_CAP: begin
                n_state = cpy_last ? mmp3_pkg::S_OUT : mmp3_pkg::S_OUT_RD;
            end
            mmp3_pkg::S_OUT:       if (!i_out_stall) n_state = mmp3_pkg::S_IDLE;
            default:               n_state = mmp3_pkg::S_IDLE;
        endcase
    end

    // Datapath and control outputs.
    always_comb begin
        n_in      = r_in;
        n_res     = r_res;
        n_exp     = r_exp;
        n_cnt     = r_cnt;
        n_i       = r_i;
        n_k       = r_k;
        n_j       = r_j;
        n_sq      = r_sq;
        n_opa     = r_opa;
        n_opb     = r_opb;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = mul_res;
        mem_raddr = '0;
        mul_start = 1'b0;
        mul_a     = r_opa;
        mul_b     = r_opb;
        mul_c     = '0;
        o_in_stall  = (r_state != mmp3_pkg::S_IDLE);
        o_out_valid = (r_state == mmp3_pkg::S_OUT);
        case (r_state)
            mmp3_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_in[0] = i_m00;
                    n_in[1] = i_m01;
                    n_in[2] = i_m02;
                    n_in[3] = i_m10;
                    n_in[4] = i_m11;
                    n_in[5] = i_m12;
                    n_in[6] = i_m20;
                    n_in[7] = i_m21;
                    n_in[8] = i_m22;
                    n_exp   = i_power;
                    n_cnt   = '0;
                end
            end
            mmp3_pkg::S_LOAD_GO: begin
                // Reducing an entry is a multiply by one.
                mul_start = 1'b1;
                mul_a     = mod_one;
                mul_b     = r_in[0];
            end
            mmp3_pkg::S_LOAD_WAIT: begin
                if (mul_done) begin
                    mem_we    = 1'b1;
                    mem_waddr = mmp3_pkg::OFS_BASE + {1'b0, r_cnt};
                    for (int e = 0; e < 8; e++) begin
                        n_in[e] = r_in[e+1];
                    end
                    n_cnt = cpy_last ? '0 : r_cnt + 1'b1;
                end
            end
            mmp3_pkg::S_INIT_ACC: begin
                mem_we    = 1'b1;
                mem_waddr = mmp3_pkg::OFS_ACC + {1'b0, r_cnt};
                mem_wdata = (r_cnt == 4'd0 || r_cnt == 4'd4 || r_cnt == 4'd8) ?
                            mod_one : '0;
                n_cnt = cpy_last ? '0 : r_cnt + 1'b1;
            end
            mmp3_pkg::S_BIT: begin
                n_sq  = !r_exp[0];
                n_i   = '0;
                n_k   = '0;
                n_j   = '0;
                n_cnt = '0;
            end
            mmp3_pkg::S_RD_A: mem_raddr = entry_addr(x_ofs, r_i, r_k);
            mmp3_pkg::S_RD_B: begin
                mem_raddr = entry_addr(mmp3_pkg::OFS_BASE, r_k, r_j);
                n_opa     = r_rdata;
            end
            mmp3_pkg::S_RD_C: begin
                mem_raddr = entry_addr(mmp3_pkg::OFS_PROD, r_i, r_j);
                n_opb     = r_rdata;
            end
            mmp3_pkg::S_MUL_GO: begin
                // The first term of each sum starts from zero.
                mul_start = 1'b1;
                mul_c     = (r_k == 2'd0) ? '0 : r_rdata;
            end
            mmp3_pkg::S_MUL_WAIT: begin
                if (mul_done) begin
                    mem_we    = 1'b1;
                    mem_waddr = entry_addr(mmp3_pkg::OFS_PROD, r_i, r_j);
                    n_j = (r_j == 2'd2) ? 2'd0 : r_j + 2'd1;
                    if (r_j == 2'd2) begin
                        n_k = (r_k == 2'd2) ? 2'd0 : r_k + 2'd1;
                        if (r_k == 2'd2) begin
                            n_i = (r_i == 2'd2) ? 2'd0 : r_i + 2'd1;
                        end
                    end
                end
            end
            mmp3_pkg::S_CPY_RD: mem_raddr = mmp3_pkg::OFS_PROD + {1'b0, r_cnt};
            mmp3_pkg::S_CPY_WR: begin
                mem_we    = 1'b1;
                mem_waddr = cpy_dst + {1'b0, r_cnt};
                mem_wdata = r_rdata;
                n_cnt     = cpy_last ? '0 : r_cnt + 1'b1;
                if (cpy_last) begin
                    if (!r_sq) begin
                        n_sq = 1'b1;
                    end else begin
                        n_exp = r_exp >> 1;
                    end
                end
            end
            mmp3_pkg::S_OUT_RD: mem_raddr = mmp3_pkg::OFS_ACC + {1'b0, r_cnt};
            mmp3_pkg::S_OUT_CAP: begin
                for (int e = 0; e < 8; e++) begin
                    n_res[e] = r_res[e+1];
                end
                n_res[8] = r_rdata;
                n_cnt    = cpy_last ? '0 : r_cnt + 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mmp3_pkg::S_IDLE;
            r_mod   <= MOD_RST;
            r_cnt   <= '0;
            r_i     <= '0;
            r_k     <= '0;
            r_j     <= '0;
            r_sq    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_mod <= i_cfg_wdata;
            end
            r_cnt <= n_cnt;
            r_i   <= n_i;
            r_k   <= n_k;
            r_j   <= n_j;
            r_sq  <= n_sq;
        end
        r_in  <= n_in;
        r_res <= n_res;
        r_exp <= n_exp;
        r_opa <= n_opa;
        r_opb <= n_opb;
    end

    assign o_r00 = r_res[0];
    assign o_r01 = r_res[1];
    assign o_r02 = r_res[2];
    assign o_r10 = r_res[3];
    assign o_r11 = r_res[4];
    assign o_r12 = r_res[5];
    assign o_r20 = r_res[6];
    assign o_r21 = r_res[7];
    assign o_r22 = r_res[8];

    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state == mmp3_pkg::S_LOAD_GO)
        else $error("accepted word did not start a load");

    a_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == mmp3_pkg::S_LOAD_WAIT ||
                      r_state == mmp3_pkg::S_MUL_WAIT))
        else $error("multiply finished outside a wait state");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= mmp3_pkg::LAST_ENTRY)
        else $error("entry counter out of range");

endmodule

`default_nettype wire

### rtl/mmp3_modmul.sv
// Bit-serial modular multiply-add unit: res = (c + a * b) mod m.
// Depends on mmp3_pkg for the default residue width.
`default_nettype none

module mmp3_modmul #(
    parameter int RESIDUE_BITS = mmp3_pkg::RESIDUE_BITS
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic [RESIDUE_BITS-1:0] i_a,
    input  wire logic [RESIDUE_BITS-1:0] i_b,
    input  wire logic [RESIDUE_BITS-1:0] i_c,
    input  wire logic [RESIDUE_BITS-1:0] i_mod,
    output logic                         o_done,
    output logic [RESIDUE_BITS-1:0]      o_res
);

    localparam int CW = $clog2(RESIDUE_BITS + 1);
    localparam logic [CW-1:0] LAST_STEP = CW'(RESIDUE_BITS - 1);

    logic                    r_busy, n_busy;
    logic                    r_fin, n_fin;
    logic                    r_done, n_done;
    logic [CW-1:0]           r_cnt, n_cnt;
    logic [RESIDUE_BITS-1:0] r_a, n_a;
    logic [RESIDUE_BITS-1:0] r_b, n_b;
    logic [RESIDUE_BITS-1:0] r_c, n_c;
    logic [RESIDUE_BITS-1:0] r_m, n_m;
    logic [RESIDUE_BITS-1:0] r_r, n_r;

    logic [RESIDUE_BITS:0] dbl, dbl_red, add_x, add_y, sum, sum_red, mod_x;

    // Partial result a < m and r < m, so every sum stays below 2m and one
    // conditional subtract brings it back into range.
    always_comb begin
        mod_x   = {1'b0, r_m};
        dbl     = {r_r, 1'b0};
        dbl_red = (dbl >= mod_x) ? dbl - mod_x : dbl;
        if (r_fin) begin
            add_x = {1'b0, r_r};
            add_y = {1'b0, r_c};
        end else begin
            add_x = dbl_red;
            add_y = r_b[RESIDUE_BITS-1] ? {1'b0, r_a} : '0;
        end
        sum     = add_x + add_y;
        sum_red = (sum >= mod_x) ? sum - mod_x : sum;
    end

    always_comb begin
        n_busy = r_busy;
        n_fin  = r_fin;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_a    = r_a;
        n_b    = r_b;
        n_c    = r_c;
        n_m    = r_m;
        n_r    = r_r;
        if (i_start) begin
            n_busy = 1'b1;
            n_fin  = 1'b0;
            n_cnt  = '0;
            n_a    = i_a;
            n_b    = i_b;
            n_c    = i_c;
            n_m    = i_mod;
            n_r    = '0;
        end else if (r_busy) begin
            n_r = sum_red[RESIDUE_BITS-1:0];
            if (r_fin) begin
                n_busy = 1'b0;
                n_fin  = 1'b0;
                n_done = 1'b1;
            end else begin
                n_b   = {r_b[RESIDUE_BITS-2:0], 1'b0};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    n_fin = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_fin  <= n_fin;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_a <= n_a;
        r_b <= n_b;
        r_c <= n_c;
        r_m <= n_m;
        r_r <= n_r;
    end

    assign o_done = r_done;
    assign o_res  = r_r;

endmodule

`default_nettype wire
